### rtl/rtbod_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rtbod_pkg
// Types, seed table and product helpers for the reciprocal 2-by-1 divider.
// ----------------------------------------------------------------------------
package rtbod_pkg;

	localparam int unsigned N_STAGES = 22;

	// operands that travel down the pipeline with each item
	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic [63:0] d;
		logic        bad;
	} opnd_t;

	// four 32x32 partial products of a 64x64 multiply
	typedef struct packed {
		logic [63:0] ll;
		logic [63:0] lh;
		logic [63:0] hl;
		logic [63:0] hh;
	} pp_t;

	typedef logic [255:0][10:0] seed_tab_t;

	// seed quotient 0x7FD00 / (256 + i), built by long division at elaboration
	function automatic seed_tab_t seed_table();
		seed_tab_t   tab;
		logic [19:0] num;
		logic [10:0] den;
		logic [10:0] rem;
		logic [19:0] quo;
		num = 20'h7FD00;
		for (int i = 0; i < 256; i++) begin
			den = 11'(i + 256);
			rem = '0;
			quo = '0;
			for (int b = 19; b >= 0; b--) begin
				rem = {rem[9:0], num[b]};
				if (rem >= den) begin
					rem = rem - den;
					quo[b] = 1'b1;
				end
			end
			tab[i] = quo[10:0];
		end
		return tab;
	endfunction

	localparam seed_tab_t SEED_TAB = seed_table();

	function automatic pp_t pp_make(input logic [63:0] a, input logic [63:0] b);
		pp_t p;
		p.ll = a[31:0] * b[31:0];
		p.lh = a[31:0] * b[63:32];
		p.hl = a[63:32] * b[31:0];
		p.hh = a[63:32] * b[63:32];
		return p;
	endfunction

	function automatic logic [127:0] pp_sum(input pp_t p);
		return 128'(p.ll) + (128'(p.lh) << 32) + (128'(p.hl) << 32) + (128'(p.hh) << 64);
	endfunction

endpackage
`default_nettype wire

### rtl/reciprocal_two_by_one_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// reciprocal_two_by_one_divider
// Divides dividend_high:dividend_low by a normalized 64-bit divisor through
// its reciprocal. One item can enter every cycle while in_stall is low. The
// chain of 32x32 partial-product multiplies and their 128-bit sums, one per
// stage, sets the pipeline depth. A stalled output holds the last stage and
// the full stages behind it; empty stages upstream keep filling. Operands
// with the divisor's top bit clear or high word not below the divisor give
// bad_operands and zero quotient and remainder.
// ----------------------------------------------------------------------------
module reciprocal_two_by_one_divider (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] dividend_high,
	input  wire logic [63:0] dividend_low,
	input  wire logic [63:0] divisor_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [63:0]      quotient_word,
	output logic [63:0]      remainder_word,
	output logic             bad_operands
);
	import rtbod_pkg::*;

	localparam int unsigned N = N_STAGES;

	logic [N:1] vld_s;
	logic [N:1] en;
	opnd_t      opnd_s [N:1];

	always_comb begin
		en[N] = !vld_s[N] || !out_stall;
		for (int k = N - 1; k >= 1; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_stall = !en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[1]) vld_s[1] <= in_valid;
			for (int k = 2; k <= N; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			opnd_s[1].hi  <= dividend_high;
			opnd_s[1].lo  <= dividend_low;
			opnd_s[1].d   <= divisor_word;
			opnd_s[1].bad <= !divisor_word[63] || (dividend_high >= divisor_word);
		end
		for (int k = 2; k <= N; k++) begin
			if (en[k]) opnd_s[k] <= opnd_s[k-1];
		end
	end

	// (d >> 24) + 1 at the stages that use it
	function automatic logic [40:0] d40_of(input logic [63:0] d);
		return 41'(d[63:24]) + 41'd1;
	endfunction

	// reciprocal: seed, two refinements
	logic [10:0]  v0_s1, v0_s2, v0_s3;
	logic [21:0]  v0sq_s2;
	logic [62:0]  p_s3;
	logic [21:0]  v1_s4, v1_s5;
	logic [63:0]  t_s5;
	logic [53:0]  tl_s6, th_s6;
	logic [21:0]  v1_s6;
	logic [63:0]  v2_s7, v2_s8, v2_s9, v2_s10, v2_s11;
	logic [63:0]  a0b0_s8, a0b1_s8, a1b0_s8;
	logic [63:0]  e_s9;
	logic [63:0]  v1_full;
	logic [63:0]  t_sum;
	logic [63:0]  d63;
	logic [63:0]  lo64_s9;

	assign v1_full = 64'({v0_s3, 11'b0}) - 64'(p_s3[62:40]) - 64'd1;
	assign t_sum   = 64'(tl_s6) + {th_s6[31:0], 32'b0};
	assign d63     = {1'b0, opnd_s[7].d[63:1]} + 64'(opnd_s[7].d[0]);
	assign lo64_s9 = a0b0_s8 + {a0b1_s8[31:0], 32'b0} + {a1b0_s8[31:0], 32'b0};

	always_ff @(posedge clk) begin
		if (en[1]) v0_s1 <= SEED_TAB[divisor_word[62:55]];
		if (en[2]) begin
			v0sq_s2 <= v0_s1 * v0_s1;
			v0_s2   <= v0_s1;
		end
		if (en[3]) begin
			p_s3  <= v0sq_s2 * d40_of(opnd_s[2].d);
			v0_s3 <= v0_s2;
		end
		if (en[4]) v1_s4 <= v1_full[21:0];
		if (en[5]) begin
			t_s5  <= 64'h1000_0000_0000_0000 - 64'(v1_s4 * d40_of(opnd_s[4].d));
			v1_s5 <= v1_s4;
		end
		if (en[6]) begin
			tl_s6 <= t_s5[31:0] * v1_s5;
			th_s6 <= t_s5[63:32] * v1_s5;
			v1_s6 <= v1_s5;
		end
		if (en[7]) v2_s7 <= 64'({v1_s6, 13'b0}) + 64'(t_sum[63:47]);
		if (en[8]) begin
			a0b0_s8 <= v2_s7[31:0] * d63[31:0];
			a0b1_s8 <= v2_s7[31:0] * d63[63:32];
			a1b0_s8 <= v2_s7[63:32] * d63[31:0];
			v2_s8   <= v2_s7;
		end
		if (en[9]) begin
			e_s9  <= ({1'b0, v2_s8[63:1]} & {64{opnd_s[8].d[0]}}) - lo64_s9;
			v2_s9 <= v2_s8;
		end
	end

	// third refinement with a full high product, then correction
	pp_t          pp_s10, pp_s13, pp_s16;
	logic [127:0] prod_s11, prod_s14, prod_s17;
	logic [63:0]  v3_s12, v3_s13, v3_s14;
	logic [63:0]  v_s15;
	logic [64:0]  pl_plus_d;

	assign pl_plus_d = 65'(prod_s14[63:0]) + 65'(opnd_s[14].d);

	always_ff @(posedge clk) begin
		if (en[10]) begin
			pp_s10 <= pp_make(v2_s9, e_s9);
			v2_s10 <= v2_s9;
		end
		if (en[11]) begin
			prod_s11 <= pp_sum(pp_s10);
			v2_s11   <= v2_s10;
		end
		if (en[12]) v3_s12 <= {v2_s11[32:0], 31'b0} + {1'b0, prod_s11[127:65]};
		if (en[13]) begin
			pp_s13 <= pp_make(v3_s12, opnd_s[12].d);
			v3_s13 <= v3_s12;
		end
		if (en[14]) begin
			prod_s14 <= pp_sum(pp_s13);
			v3_s14   <= v3_s13;
		end
		if (en[15]) begin
			v_s15 <= v3_s14 - opnd_s[14].d - prod_s14[127:64] - 64'(pl_plus_d[64]);
		end
		if (en[16]) pp_s16 <= pp_make(opnd_s[15].hi, v_s15);
		if (en[17]) prod_s17 <= pp_sum(pp_s16);
	end

	// quotient estimate and corrections
	logic [63:0] q1_s18, q0_s18, q1_s19, q0_s19, q1_s20, q0_s20;
	logic [63:0] q1_s21, r_s20, r_s21, q1_s22, r_s22;
	logic        bad_s22;
	logic [63:0] b0_s19, b1_s19, b2_s19;
	logic [64:0] sum_lo;
	logic [63:0] qd_lo;

	assign sum_lo = 65'(prod_s17[63:0]) + 65'(opnd_s[17].lo);
	assign qd_lo  = b0_s19 + {b1_s19[31:0], 32'b0} + {b2_s19[31:0], 32'b0};

	always_ff @(posedge clk) begin
		if (en[18]) begin
			q1_s18 <= prod_s17[127:64] + opnd_s[17].hi + 64'(sum_lo[64]) + 64'd1;
			q0_s18 <= sum_lo[63:0];
		end
		if (en[19]) begin
			b0_s19 <= q1_s18[31:0] * opnd_s[18].d[31:0];
			b1_s19 <= q1_s18[31:0] * opnd_s[18].d[63:32];
			b2_s19 <= q1_s18[63:32] * opnd_s[18].d[31:0];
			q1_s19 <= q1_s18;
			q0_s19 <= q0_s18;
		end
		if (en[20]) begin
			r_s20  <= opnd_s[19].lo - qd_lo;
			q1_s20 <= q1_s19;
			q0_s20 <= q0_s19;
		end
		if (en[21]) begin
			if (r_s20 > q0_s20) begin
				q1_s21 <= q1_s20 - 64'd1;
				r_s21  <= r_s20 + opnd_s[20].d;
			end else begin
				q1_s21 <= q1_s20;
				r_s21  <= r_s20;
			end
		end
		if (en[22]) begin
			bad_s22 <= opnd_s[21].bad;
			if (opnd_s[21].bad) begin
				q1_s22 <= '0;
				r_s22  <= '0;
			end else if (r_s21 >= opnd_s[21].d) begin
				q1_s22 <= q1_s21 + 64'd1;
				r_s22  <= r_s21 - opnd_s[21].d;
			end else begin
				q1_s22 <= q1_s21;
				r_s22  <= r_s21;
			end
		end
	end

	assign out_valid      = vld_s[N];
	assign quotient_word  = q1_s22;
	assign remainder_word = r_s22;
	assign bad_operands   = bad_s22;

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_operands |-> quotient_word == '0 && remainder_word == '0)
		else $error("bad operands with nonzero result");

	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !bad_operands |-> remainder_word < opnd_s[N].d)
		else $error("remainder not below divisor");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_stall && (&vld_s))
		else $error("input stalled with a free stage");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[N] && !out_stall && !vld_s[N-1] |=> !vld_s[N])
		else $error("result repeated after hand-off");

endmodule
`default_nettype wire
